// ===== rtl/core/tpcl_pkg.sv =====
package tpcl_pkg;

   localparam int KEY_W      = 64;
   localparam int CNT_W      = 16;
   localparam int LIM_W      = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CNT_W-1:0] CNT_MAX   = '1;
   localparam logic [CNT_W-1:0] CNT_FIRST = CNT_W'(1);
   localparam logic [CNT_W-1:0] THR_RESET = CNT_W'(2);
   localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(16);

   localparam logic [CSR_IDX_W-1:0] REG_PROMOTE_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_CAPACITY_LIMIT    = 1'b1;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_LOAD,
      OP_LOOKUP,
      OP_UPDATE,
      OP_ROTATE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      clear_dump;
   } dp_cmd_type;

   typedef struct packed {
      logic dump_last;
   } dp_status_type;

endpackage

// ===== rtl/core/tpcl_req_if.sv =====
interface tpcl_req_if;
   logic                      valid;
   logic                      ready;
   logic [tpcl_pkg::KEY_W-1:0] access_key;

   modport source (output valid, output access_key, input ready);
   modport sink (input valid, input access_key, output ready);
endinterface

// ===== rtl/core/tpcl_rsp_if.sv =====
interface tpcl_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [tpcl_pkg::KEY_W-1:0] entry_key;
   logic [tpcl_pkg::CNT_W-1:0] entry_count;
   logic                      is_last;

   modport source (output valid, output entry_key, output entry_count, output is_last,
                   input ready);
   modport sink (input valid, input entry_key, input entry_count, input is_last,
                 output ready);
endinterface

// ===== rtl/core/tpcl_ctrl.sv =====
module tpcl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tpcl_pkg::dp_cmd_type    cmd,
   input  tpcl_pkg::dp_status_type status
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_UPDATE,
      S_DUMP
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd.op         = tpcl_pkg::OP_IDLE;
      cmd.clear_dump = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready_in = 1'b1;
            if (req_ready_ff && req_valid) begin
               cmd.op         = tpcl_pkg::OP_LOAD;
               cmd.clear_dump = 1'b1;
               req_ready_in   = 1'b0;
               state_in       = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            cmd.op   = tpcl_pkg::OP_LOOKUP;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.op       = tpcl_pkg::OP_UPDATE;
            rsp_valid_in = 1'b1;
            state_in     = S_DUMP;
         end
         S_DUMP: begin
            if (rsp_ready) begin
               cmd.op = tpcl_pkg::OP_ROTATE;
               if (status.dump_last) begin
                  rsp_valid_in = 1'b0;
                  req_ready_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/tpcl_datapath.sv =====
module tpcl_datapath #(
   parameter int CAP = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tpcl_pkg::dp_cmd_type                cmd,
   output tpcl_pkg::dp_status_type             status,
   input  logic [tpcl_pkg::KEY_W-1:0]          access_key,
   output logic [tpcl_pkg::KEY_W-1:0]          entry_key,
   output logic [tpcl_pkg::CNT_W-1:0]          entry_count,
   input  logic                                csr_we,
   input  logic [tpcl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tpcl_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
   localparam int OCC_W = $clog2(CAP + 1);

   logic [tpcl_pkg::KEY_W-1:0] key_ff [CAP];
   logic [tpcl_pkg::KEY_W-1:0] key_in [CAP];
   logic [tpcl_pkg::CNT_W-1:0] cnt_ff [CAP];
   logic [tpcl_pkg::CNT_W-1:0] cnt_in [CAP];

   logic [tpcl_pkg::KEY_W-1:0] acc_key_ff;
   logic [CAP-1:0]             hit_ff, hit_in;
   logic [OCC_W-1:0]           occ_ff, occ_in;
   logic [IDX_W-1:0]           dump_ff, dump_in;
   logic [tpcl_pkg::CNT_W-1:0] thr_ff;
   logic [tpcl_pkg::LIM_W-1:0] lim_ff;

   logic [OCC_W-1:0]           occ_m1;
   logic [OCC_W-1:0]           eff_lim;
   logic [OCC_W:0]             occ_base;
   logic [IDX_W-1:0]           hit_pos;
   logic [tpcl_pkg::CNT_W-1:0] hit_cnt;
   logic [tpcl_pkg::CNT_W-1:0] new_cnt;
   logic                       found;
   logic                       promote;

   assign occ_m1 = occ_ff - OCC_W'(1);

   // Entries are distinct, so at most one hit bit is set and an OR selects it.
   always_comb begin
      hit_pos = '0;
      hit_cnt = '0;
      for (int i = 0; i < CAP; i++) begin
         hit_pos = hit_pos | (hit_ff[i] ? IDX_W'(i) : '0);
         hit_cnt = hit_cnt | (hit_ff[i] ? cnt_ff[i] : '0);
      end
   end

   assign found   = |hit_ff;
   assign new_cnt = (hit_cnt == tpcl_pkg::CNT_MAX) ? hit_cnt : hit_cnt + tpcl_pkg::CNT_W'(1);
   // The count has just reached threshold plus one, and the entry is not already in front.
   assign promote = found && (hit_cnt != tpcl_pkg::CNT_MAX) && (hit_cnt == thr_ff) && !hit_ff[0];

   always_comb begin
      if (lim_ff == '0) begin
         eff_lim = OCC_W'(1);
      end else if (int'(lim_ff) > CAP) begin
         eff_lim = OCC_W'(CAP);
      end else begin
         eff_lim = OCC_W'(lim_ff);
      end
   end

   always_comb begin
      occ_base = found ? {1'b0, occ_ff} : {1'b0, occ_ff} + (OCC_W + 1)'(1);
      occ_in   = occ_ff;
      if (cmd.op == tpcl_pkg::OP_UPDATE) begin
         occ_in = (occ_base > {1'b0, eff_lim}) ? eff_lim : occ_base[OCC_W-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < CAP; i++) begin
         hit_in[i] = (OCC_W'(i) < occ_ff) && (key_ff[i] == acc_key_ff);
      end
   end

   always_comb begin
      dump_in = dump_ff;
      if (cmd.clear_dump) begin
         dump_in = '0;
      end else if (cmd.op == tpcl_pkg::OP_ROTATE) begin
         dump_in = dump_ff + IDX_W'(1);
      end
   end

   for (genvar g = 0; g < CAP; g++) begin : g_pos
      localparam logic [OCC_W-1:0] POS_OCC = OCC_W'(g);
      localparam logic [IDX_W-1:0] POS_IDX = IDX_W'(g);

      always_comb begin
         key_in[g] = key_ff[g];
         cnt_in[g] = cnt_ff[g];
         case (cmd.op)
            tpcl_pkg::OP_UPDATE: begin
               if (!found || promote) begin
                  if (g == 0) begin
                     key_in[g] = acc_key_ff;
                     cnt_in[g] = found ? new_cnt : tpcl_pkg::CNT_FIRST;
                  end else if (!found || (POS_IDX <= hit_pos)) begin
                     key_in[g] = key_ff[(g > 0) ? g - 1 : 0];
                     cnt_in[g] = cnt_ff[(g > 0) ? g - 1 : 0];
                  end
               end else if (hit_ff[g]) begin
                  cnt_in[g] = new_cnt;
               end
            end
            // The dump turns the occupied part of the list like a ring, head out first.
            tpcl_pkg::OP_ROTATE: begin
               if (POS_OCC < occ_m1) begin
                  key_in[g] = key_ff[(g < CAP - 1) ? g + 1 : g];
                  cnt_in[g] = cnt_ff[(g < CAP - 1) ? g + 1 : g];
               end else if (POS_OCC == occ_m1) begin
                  key_in[g] = key_ff[0];
                  cnt_in[g] = cnt_ff[0];
               end
            end
            default: begin
            end
         endcase
      end

      always_ff @(posedge clock) begin
         key_ff[g] <= key_in[g];
         cnt_ff[g] <= cnt_in[g];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == tpcl_pkg::OP_LOAD) begin
         acc_key_ff <= access_key;
      end
      if (cmd.op == tpcl_pkg::OP_LOOKUP) begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff  <= '0;
         dump_ff <= '0;
         thr_ff  <= tpcl_pkg::THR_RESET;
         lim_ff  <= tpcl_pkg::LIM_RESET;
      end else begin
         occ_ff  <= occ_in;
         dump_ff <= dump_in;
         if (csr_we) begin
            case (csr_index)
               tpcl_pkg::REG_PROMOTE_THRESHOLD: thr_ff <= csr_wdata[tpcl_pkg::CNT_W-1:0];
               tpcl_pkg::REG_CAPACITY_LIMIT:    lim_ff <= csr_wdata[tpcl_pkg::LIM_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign entry_key         = key_ff[0];
   assign entry_count       = cnt_ff[0];
   assign status.dump_last  = (OCC_W'(dump_ff) == occ_m1);

endmodule

// ===== rtl/core/threshold_promote_cache_list.sv =====
// Channel   Dir  Handshake          Payload
// req_ch    in   valid/ready        access_key[63:0]
// rsp_ch    out  valid/ready        entry_key[63:0], entry_count[15:0], is_last
// csr       in   csr_we, no wait    csr_index[0], csr_wdata[15:0]
//
// Each item passes through accept, lookup and update, then the dump offers one list
// entry per cycle while rsp_ch.ready is high.
// The dump shifts the list past its head register.
// Reset (synchronous) empties the list and loads threshold 2 and capacity 16.
// A stall on rsp_ch holds the dump in place; req_ch is not ready until it ends.
module threshold_promote_cache_list #(
   parameter int CAP = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   tpcl_req_if.sink                            req_ch,
   tpcl_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [tpcl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tpcl_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   tpcl_pkg::dp_cmd_type    cmd;
   tpcl_pkg::dp_status_type status;

   tpcl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   tpcl_datapath #(
      .CAP (CAP)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .access_key  (req_ch.access_key),
      .entry_key   (rsp_ch.entry_key),
      .entry_count (rsp_ch.entry_count),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   assign rsp_ch.is_last = status.dump_last;

endmodule

// ===== rtl/core/tpcl_checker.sv =====
module tpcl_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_is_last
);

   // A result waiting on the sink stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped before the item was taken");

   // The block works on one item at a time: no new item while results are out.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req ready while a dump is in progress");

   a_lookup_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid && !req_ready)
      else $error("result or new item right after an accept");

   a_dump_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_is_last |=> !rsp_valid)
      else $error("result offered after the last entry");

   a_dump_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_is_last |=> rsp_valid)
      else $error("dump stopped before the last entry");

endmodule

bind threshold_promote_cache_list tpcl_checker u_tpcl_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_is_last (rsp_ch.is_last)
);

// ===== bench/tpcl_dump_check.sv =====
`timescale 1ns / 1ps

module tpcl_dump_check #(
   parameter int CAP = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   tpcl_req_if                                  req_mon,
   tpcl_rsp_if                                  rsp_mon,
   input  logic                                 csr_we,
   input  logic [tpcl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tpcl_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output int                                   failures,
   output int                                   pending,
   output int                                   checked
);

   typedef struct packed {
      logic [tpcl_pkg::KEY_W-1:0] key;
      logic [tpcl_pkg::CNT_W-1:0] count;
      logic                       last;
   } list_entry_type;

   list_entry_type expected_dump[$];
   list_entry_type want;

   // One spare slot holds a new key before the tail is cut back.
   logic [tpcl_pkg::KEY_W-1:0] lru_keys   [0:CAP];
   logic [tpcl_pkg::CNT_W-1:0] lru_counts [0:CAP];
   int                         occupancy = 0;
   logic [tpcl_pkg::CNT_W-1:0] threshold = tpcl_pkg::THR_RESET;
   logic [tpcl_pkg::LIM_W-1:0] capacity  = tpcl_pkg::LIM_RESET;

   int fail_total    = 0;
   int checked_total = 0;

   task automatic report_mismatch(input string what, input logic [tpcl_pkg::KEY_W-1:0] got,
                                  input logic [tpcl_pkg::KEY_W-1:0] exp_val);
      $display("%0t ns mismatch: %s got %0h, wanted %0h", $time, what, got, exp_val);
      fail_total++;
   endtask

   task automatic bring_to_front(input int pos);
      logic [tpcl_pkg::KEY_W-1:0] k;
      logic [tpcl_pkg::CNT_W-1:0] c;
      k = lru_keys[pos];
      c = lru_counts[pos];
      for (int i = pos; i > 0; i--) begin
         lru_keys[i]   = lru_keys[i-1];
         lru_counts[i] = lru_counts[i-1];
      end
      lru_keys[0]   = k;
      lru_counts[0] = c;
   endtask

   task automatic predict_list_dump(input logic [tpcl_pkg::KEY_W-1:0] key);
      logic [tpcl_pkg::CNT_W:0] target;
      int                       lim;
      int                       pos;
      bit                       hit;
      bit                       bumped;
      list_entry_type           e;
      target = {1'b0, threshold} + 1'b1;
      lim = int'(capacity);
      if (lim < 1) lim = 1;
      if (lim > CAP) lim = CAP;
      hit = 1'b0;
      bumped = 1'b0;
      pos = 0;
      for (int i = 0; i < occupancy; i++) begin
         if (!hit && lru_keys[i] == key) begin
            pos = i;
            hit = 1'b1;
         end
      end
      if (hit) begin
         // A saturated count stays put and does not count as reaching the target.
         if (lru_counts[pos] != tpcl_pkg::CNT_MAX) begin
            lru_counts[pos] = lru_counts[pos] + 1'b1;
            bumped = 1'b1;
         end
      end else begin
         lru_keys[occupancy]   = key;
         lru_counts[occupancy] = tpcl_pkg::CNT_FIRST;
         bring_to_front(occupancy);
         occupancy++;
         pos = 0;
         bumped = 1'b1;
      end
      if (bumped && {1'b0, lru_counts[pos]} == target && pos != 0)
         bring_to_front(pos);
      if (occupancy > lim)
         occupancy = lim;
      for (int i = 0; i < occupancy; i++) begin
         e.key   = lru_keys[i];
         e.count = lru_counts[i];
         e.last  = (i == occupancy - 1);
         expected_dump.push_back(e);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         occupancy = 0;
         threshold = tpcl_pkg::THR_RESET;
         capacity  = tpcl_pkg::LIM_RESET;
         expected_dump.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_dump.size() == 0) begin
               report_mismatch("entry with nothing expected, key", rsp_mon.entry_key, '0);
            end else begin
               want = expected_dump.pop_front();
               checked_total++;
               if (rsp_mon.entry_key !== want.key)
                  report_mismatch("entry_key", rsp_mon.entry_key, want.key);
               if (rsp_mon.entry_count !== want.count)
                  report_mismatch("entry_count", tpcl_pkg::KEY_W'(rsp_mon.entry_count),
                                  tpcl_pkg::KEY_W'(want.count));
               if (rsp_mon.is_last !== want.last)
                  report_mismatch("is_last", tpcl_pkg::KEY_W'(rsp_mon.is_last),
                                  tpcl_pkg::KEY_W'(want.last));
            end
         end
         if (req_mon.valid && req_mon.ready)
            predict_list_dump(req_mon.access_key);
         if (csr_we) begin
            case (csr_index)
               tpcl_pkg::REG_PROMOTE_THRESHOLD: threshold = csr_wdata[tpcl_pkg::CNT_W-1:0];
               tpcl_pkg::REG_CAPACITY_LIMIT:    capacity  = csr_wdata[tpcl_pkg::LIM_W-1:0];
               default: ;
            endcase
         end
      end
      failures <= fail_total;
      pending  <= expected_dump.size();
      checked  <= checked_total;
   end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int CAP           = 16;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 24;
   localparam int POOL_SIZE     = 24;
   localparam int PHASE_ITEMS   = 76;

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 csr_we;
   logic [tpcl_pkg::CSR_IDX_W-1:0]       csr_index;
   logic [tpcl_pkg::CSR_DATA_W-1:0]      csr_wdata;

   tpcl_req_if req_ch ();
   tpcl_rsp_if rsp_ch ();

   int failures;
   int pending;
   int checked;

   bit req_idle_en   = 1'b1;
   bit rsp_idle_en   = 1'b1;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int items_sent    = 0;
   int settings_used = 0;

   logic [tpcl_pkg::KEY_W-1:0] key_pool [0:POOL_SIZE-1];

   threshold_promote_cache_list #(.CAP(CAP)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tpcl_dump_check #(.CAP(CAP)) dump_check (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_ch),
      .rsp_mon   (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .failures  (failures),
      .pending   (pending),
      .checked   (checked)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !rsp_idle_en || ($urandom_range(99) >= 24);
         end
      end
   end

   task automatic send_access(input logic [tpcl_pkg::KEY_W-1:0] key);
      if (req_idle_en && $urandom_range(99) < 24) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.access_key <= key;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain_list();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [tpcl_pkg::CNT_W-1:0] thr,
                             input logic [tpcl_pkg::LIM_W-1:0] cap);
      logic [tpcl_pkg::CSR_DATA_W-tpcl_pkg::LIM_W-1:0] upper;
      upper = (tpcl_pkg::CSR_DATA_W - tpcl_pkg::LIM_W)'($urandom);
      drain_list();
      csr_we    <= 1'b1;
      csr_index <= tpcl_pkg::REG_PROMOTE_THRESHOLD;
      csr_wdata <= thr;
      @(posedge clock);
      // Bits above the capacity field are ignored by the block.
      csr_index <= tpcl_pkg::REG_CAPACITY_LIMIT;
      csr_wdata <= {upper, cap};
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [tpcl_pkg::KEY_W-1:0] pick_key(input int hot);
      int roll;
      roll = $urandom_range(99);
      if (roll < 75)
         return key_pool[$urandom_range(hot - 1)];
      else if (roll < 92)
         return {$urandom, $urandom};
      else if (roll < 96)
         return '0;
      else
         return '1;
   endfunction

   initial begin
      #400000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int hot;
      int cap_eff;
      logic [tpcl_pkg::CNT_W-1:0] thr;
      logic [tpcl_pkg::LIM_W-1:0] cap;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = tpcl_pkg::REG_PROMOTE_THRESHOLD;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.access_key = '0;
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = {$urandom, $urandom};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: the second hit on a key that is not at the front promotes it.
      send_access('0);
      send_access('1);
      send_access('0);
      send_access('0);
      // Overfill the list so that the tail is evicted.
      for (int i = 1; i <= 15; i++)
         send_access(key_pool[i]);

      // Capacity lowered while full, threshold zero on a fresh key.
      set_config(tpcl_pkg::CNT_W'(0), tpcl_pkg::LIM_W'(3));
      send_access(64'h5555_5555_5555_5555);
      send_access(key_pool[15]);
      send_access(64'hAAAA_AAAA_AAAA_AAAA);

      // Capacity zero acts as one; the top threshold never promotes.
      set_config(tpcl_pkg::CNT_MAX, tpcl_pkg::LIM_W'(0));
      send_access(key_pool[3]);
      send_access(key_pool[3]);
      send_access(key_pool[4]);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin thr = tpcl_pkg::CNT_W'(5);  cap = tpcl_pkg::LIM_W'(31); end
            1: begin thr = tpcl_pkg::THR_RESET;  cap = tpcl_pkg::LIM_RESET;  end
            2: begin thr = tpcl_pkg::CNT_W'(1);  cap = tpcl_pkg::LIM_W'(4);  end
            3: begin thr = tpcl_pkg::CNT_MAX;    cap = tpcl_pkg::LIM_W'(8);  end
            4: begin thr = tpcl_pkg::CNT_W'(0);  cap = tpcl_pkg::LIM_W'(1);  end
            default: begin
               thr = tpcl_pkg::CNT_W'($urandom_range(0, 20));
               cap = tpcl_pkg::LIM_W'($urandom_range(0, 31));
            end
         endcase
         set_config(thr, cap);
         cap_eff = (cap == 0) ? 1 : ((cap > CAP) ? CAP : int'(cap));
         hot = $urandom_range(2, (cap_eff + 6 > POOL_SIZE) ? POOL_SIZE : cap_eff + 6);
         req_idle_en = (phase != 2);
         rsp_idle_en <= (phase != 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 1 && n == 20)
               hold_requests <= hold_requests + 1;
            send_access(pick_key(hot));
         end
      end

      drain_list();
      $display("Sent %0d access items under %0d register settings; %0d list entries compared.",
               items_sent, settings_used, checked);
      $display("Covered hits, promotion, eviction, capacity clamping and a long receiver stall.");
      if (failures == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
